// ===== hw/rtl/sinr_est_pkg.sv =====
// Shared constants, register codes and stage structs of the SINR estimator.
`default_nettype none
package sinr_est_pkg;

  localparam int unsigned MAX_SUBCARRIERS = 1024;
  localparam int unsigned AVG_W     = 48;
  localparam int unsigned SMP_W     = 16;
  localparam int unsigned PWR_W     = 32;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned ALPHA_W   = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned EST_W     = 32;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned FRAC_W    = 16;

  localparam logic [AVG_W-1:0] ONE_Q46 = 48'h4000_0000_0000;
  localparam logic [EST_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [EST_W-1:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [15:0]      Q_LIMIT = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE = 2'd0,
    REG_SKIP   = 2'd1,
    REG_ALPHA  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   spc;
    logic [ALPHA_W-1:0] alpha;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [AVG_W-1:0] ref_avg;
    logic [AVG_W-1:0] meas_avg;
  } avg_t;

  typedef struct packed {
    logic             valid;
    logic [EST_W-1:0] est;
    logic [IDX_W-1:0] idx;
    logic             sat;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sinr_est_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sinr_est_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [0:Depth-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sinr_est_avg.sv =====
// Position tracking, power computation and read-modify-write of the average stores.
`default_nettype none
module sinr_est_avg #(
  parameter int unsigned MaxSub = sinr_est_pkg::MAX_SUBCARRIERS
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire sinr_est_pkg::cfg_t                       cfg_i,
  input  wire logic                                     adv_i,
  input  wire logic                                     accept_i,
  input  wire logic signed [sinr_est_pkg::SMP_W-1:0]    ref_re_i,
  input  wire logic signed [sinr_est_pkg::SMP_W-1:0]    ref_im_i,
  input  wire logic signed [sinr_est_pkg::SMP_W-1:0]    meas_re_i,
  input  wire logic signed [sinr_est_pkg::SMP_W-1:0]    meas_im_i,
  output logic                                          busy_o,
  output sinr_est_pkg::avg_t                            avg_o
);

  localparam int unsigned PosW  = $clog2(MaxSub);
  localparam int unsigned AW    = sinr_est_pkg::AVG_W;
  localparam int unsigned PW    = sinr_est_pkg::PWR_W;
  localparam int unsigned CW    = sinr_est_pkg::CNT_W;
  localparam int unsigned HalfW = AW / 2;
  localparam int unsigned ProdW = HalfW + sinr_est_pkg::ALPHA_W + 1;
  localparam int unsigned MulW  = PW + sinr_est_pkg::ALPHA_W;

  function automatic logic [AW-1:0] blend(input logic [MulW-1:0] a,
                                          input logic [ProdW-1:0] lo,
                                          input logic [ProdW-1:0] hi);
    logic [AW+17:0] acc;
    acc = {2'b00, a, 16'h0000} + (AW+18)'(lo) + ((AW+18)'(hi) << HalfW)
        + (AW+18)'(32768);
    return acc[AW+15:16];
  endfunction

  logic [PosW-1:0] pos_q, pos_d, ph_q, ph_d;
  logic [CW-1:0]   len_eff, spc_eff, pos_nx, ph_nx;
  logic            clr_q;
  logic [PosW-1:0] clr_cnt_q;

  logic            s1_v_q, s2_v_q, s3_v_q;
  logic [PosW-1:0] s1_pos_q, s2_pos_q, s3_pos_q;
  logic [PW-1:0]   s1_pr_q, s1_pm_q;
  logic [MulW-1:0] s2_ra_q, s2_ma_q;
  logic [ProdW-1:0] s2_rlo_q, s2_rhi_q, s2_mlo_q, s2_mhi_q;
  logic [AW-1:0]   s3_r_q, s3_m_q;

  logic [AW-1:0]   rd_r, rd_m, old_r, old_m, new_r, new_m;
  logic [16:0]     beta;
  logic signed [31:0] sq_rr, sq_ri, sq_mr, sq_mi;
  logic            fwd, we;
  logic [PosW-1:0] waddr;
  logic [AW-1:0]   wdata_r, wdata_m;

  always_comb begin
    if (cfg_i.len == '0) begin
      len_eff = CW'(1);
    end else if (CW'(cfg_i.len) > CW'(MaxSub)) begin
      len_eff = CW'(MaxSub);
    end else begin
      len_eff = CW'(cfg_i.len);
    end
    spc_eff = (cfg_i.spc == '0) ? CW'(1) : CW'(cfg_i.spc);
    pos_nx  = CW'(pos_q) + CW'(1);
    ph_nx   = CW'(ph_q) + CW'(1);
    if (pos_nx >= len_eff) begin
      pos_d = '0;
      ph_d  = '0;
    end else begin
      pos_d = PosW'(pos_nx);
      ph_d  = (ph_nx >= spc_eff) ? '0 : PosW'(ph_nx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      ph_q      <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + PosW'(1);
        if (clr_cnt_q == PosW'(MaxSub - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (accept_i) begin
        pos_q <= pos_d;
        ph_q  <= ph_d;
      end
      if (adv_i) begin
        s1_v_q <= accept_i && (ph_q != '0);
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
      end
    end
  end

  assign sq_rr = ref_re_i * ref_re_i;
  assign sq_ri = ref_im_i * ref_im_i;
  assign sq_mr = meas_re_i * meas_re_i;
  assign sq_mi = meas_im_i * meas_im_i;

  assign fwd   = s3_v_q && (s3_pos_q == s1_pos_q);
  assign old_r = fwd ? s3_r_q : rd_r;
  assign old_m = fwd ? s3_m_q : rd_m;
  assign beta  = 17'h1_0000 - {1'b0, cfg_i.alpha};
  assign new_r = blend(s2_ra_q, s2_rlo_q, s2_rhi_q);
  assign new_m = blend(s2_ma_q, s2_mlo_q, s2_mhi_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_pos_q <= pos_q;
      s1_pr_q  <= PW'($unsigned(sq_rr)) + PW'($unsigned(sq_ri));
      s1_pm_q  <= PW'($unsigned(sq_mr)) + PW'($unsigned(sq_mi));
      s2_pos_q <= s1_pos_q;
      s2_ra_q  <= cfg_i.alpha * s1_pr_q;
      s2_ma_q  <= cfg_i.alpha * s1_pm_q;
      s2_rlo_q <= beta * old_r[HalfW-1:0];
      s2_rhi_q <= beta * old_r[AW-1:HalfW];
      s2_mlo_q <= beta * old_m[HalfW-1:0];
      s2_mhi_q <= beta * old_m[AW-1:HalfW];
      s3_pos_q <= s2_pos_q;
      s3_r_q   <= new_r;
      s3_m_q   <= new_m;
    end
  end

  assign we      = clr_q || (adv_i && s2_v_q);
  assign waddr   = clr_q ? clr_cnt_q : s2_pos_q;
  assign wdata_r = clr_q ? sinr_est_pkg::ONE_Q46 : new_r;
  assign wdata_m = clr_q ? sinr_est_pkg::ONE_Q46 : new_m;

  sinr_est_ram #(.Width(AW), .Depth(MaxSub)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata_r),
    .re_i    (adv_i),
    .raddr_i (pos_q),
    .rdata_o (rd_r)
  );

  sinr_est_ram #(.Width(AW), .Depth(MaxSub)) u_meas_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata_m),
    .re_i    (adv_i),
    .raddr_i (pos_q),
    .rdata_o (rd_m)
  );

  assign busy_o = clr_q;
  assign avg_o  = {s3_v_q, sinr_est_pkg::IDX_W'(s3_pos_q), s3_r_q, s3_m_q};

  a_no_adjacent_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s2_v_q) |-> (s1_pos_q != s2_pos_q))
    else $error("adjacent updates hit one entry");
  a_empty_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (!s1_v_q && !s2_v_q && !accept_i))
    else $error("update during clearing pass");
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(pos_q) < CW'(MaxSub))
    else $error("position beyond store depth");

endmodule
`default_nettype wire

// ===== hw/rtl/sinr_est_div.sv =====
// Pipelined restoring divider and saturation of the averaged power ratio.
`default_nettype none
module sinr_est_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire sinr_est_pkg::avg_t  avg_i,
  output sinr_est_pkg::res_t       res_o
);

  localparam int unsigned AW = sinr_est_pkg::AVG_W;
  localparam int unsigned NS = sinr_est_pkg::DIV_STEPS;
  localparam int unsigned FW = sinr_est_pkg::FRAC_W;
  localparam int unsigned EW = sinr_est_pkg::EST_W;
  localparam int unsigned IW = sinr_est_pkg::IDX_W;

  logic [NS:0]   v_q;
  logic [NS:0]   zero_q, ovf_q;
  logic [AW-1:0] rem_q [0:NS];
  logic [AW-1:0] dvs_q [0:NS];
  logic [FW-1:0] lo_q  [0:NS];
  logic [EW-1:0] quo_q [0:NS];
  logic [IW-1:0] idx_q [0:NS];

  sinr_est_pkg::res_t res_q;
  logic               sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      res_q <= '0;
    end else if (adv_i) begin
      v_q         <= {v_q[NS-1:0], avg_i.valid};
      res_q.valid <= v_q[NS];
      res_q.sat   <= sat;
      res_q.idx   <= idx_q[NS];
      res_q.est   <= sat ? sinr_est_pkg::SAT_MAX : quo_q[NS] - sinr_est_pkg::ONE_Q16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      zero_q[0] <= (avg_i.ref_avg == '0);
      ovf_q[0]  <= {{FW{1'b0}}, avg_i.meas_avg} >= {avg_i.ref_avg, {FW{1'b0}}};
      rem_q[0]  <= AW'(avg_i.meas_avg[AW-1:FW]);
      dvs_q[0]  <= avg_i.ref_avg;
      lo_q[0]   <= avg_i.meas_avg[FW-1:0];
      quo_q[0]  <= '0;
      idx_q[0]  <= avg_i.idx;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [AW:0] sh;
    logic        ge;
    assign sh = {rem_q[k], lo_q[k][FW-1]};
    assign ge = sh >= {1'b0, dvs_q[k]};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k+1]  <= ge ? AW'(sh - {1'b0, dvs_q[k]}) : sh[AW-1:0];
        quo_q[k+1]  <= {quo_q[k][EW-2:0], ge};
        lo_q[k+1]   <= {lo_q[k][FW-2:0], 1'b0};
        dvs_q[k+1]  <= dvs_q[k];
        zero_q[k+1] <= zero_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        idx_q[k+1]  <= idx_q[k];
      end
    end
  end

  assign sat = zero_q[NS] || ovf_q[NS]
            || (quo_q[NS][EW-1:FW] > sinr_est_pkg::Q_LIMIT);

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/per_subcarrier_sinr_estimator_unit.sv =====
// Top level of the per-subcarrier SINR estimator: config registers and output buffer.
// Throughput: one word per cycle unless the output stalls or the stores are clearing,
// set by the single read-modify-write pass per item. Results pass through the
//   3-stage average update and the 32-step divider pipeline.
// Skipped positions are accepted but give no result.
// Reset: the stores are cleared to 1.0 entry by entry while input is stalled.
`default_nettype none
module per_subcarrier_sinr_estimator_unit #(
  parameter int unsigned MaxSub = sinr_est_pkg::MAX_SUBCARRIERS
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      cfg_we_i,
  input  wire logic [sinr_est_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [sinr_est_pkg::CFG_W-1:0]            cfg_data_i,
  input  wire logic                                      in_valid_i,
  output logic                                           in_stall_o,
  input  wire logic signed [sinr_est_pkg::SMP_W-1:0]     ref_re_i,
  input  wire logic signed [sinr_est_pkg::SMP_W-1:0]     ref_im_i,
  input  wire logic signed [sinr_est_pkg::SMP_W-1:0]     meas_re_i,
  input  wire logic signed [sinr_est_pkg::SMP_W-1:0]     meas_im_i,
  output logic                                           out_valid_o,
  input  wire logic                                      out_stall_i,
  output logic signed [sinr_est_pkg::EST_W-1:0]          sinr_estimate_o,
  output logic [sinr_est_pkg::IDX_W-1:0]                 subcarrier_index_o,
  output logic                                           saturated_o
);

  sinr_est_pkg::cfg_t cfg_q;
  sinr_est_pkg::avg_t avg;
  sinr_est_pkg::res_t res, out_q, skid_q;
  logic               busy, adv, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.len   <= sinr_est_pkg::LEN_W'(64);
      cfg_q.spc   <= sinr_est_pkg::LEN_W'(4);
      cfg_q.alpha <= sinr_est_pkg::ALPHA_W'(655);
    end else if (cfg_we_i) begin
      unique case (sinr_est_pkg::cfg_reg_e'(cfg_idx_i))
        sinr_est_pkg::REG_ACTIVE: cfg_q.len   <= cfg_data_i[sinr_est_pkg::LEN_W-1:0];
        sinr_est_pkg::REG_SKIP:   cfg_q.spc   <= cfg_data_i[sinr_est_pkg::LEN_W-1:0];
        sinr_est_pkg::REG_ALPHA:  cfg_q.alpha <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = !skid_q.valid;
  assign in_stall_o = skid_q.valid || busy;
  assign accept     = in_valid_i && !in_stall_o;

  sinr_est_avg #(.MaxSub(MaxSub)) u_avg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .adv_i     (adv),
    .accept_i  (accept),
    .ref_re_i  (ref_re_i),
    .ref_im_i  (ref_im_i),
    .meas_re_i (meas_re_i),
    .meas_im_i (meas_im_i),
    .busy_o    (busy),
    .avg_o     (avg)
  );

  sinr_est_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .avg_i  (avg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      skid_q <= '0;
    end else if (!out_q.valid || !out_stall_i) begin
      if (skid_q.valid) begin
        out_q <= skid_q;
      end else if (adv && res.valid) begin
        out_q <= res;
      end else begin
        out_q.valid <= 1'b0;
      end
      skid_q.valid <= 1'b0;
    end else if (adv && res.valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o        = out_q.valid;
  assign sinr_estimate_o    = out_q.est;
  assign subcarrier_index_o = out_q.idx;
  assign saturated_o        = out_q.sat;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q.valid |-> out_q.valid)
    else $error("skid word without output word");
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q.valid && out_stall_i) |=> skid_q.valid)
    else $error("skid word lost under stall");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the per-subcarrier SINR estimator with its own predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  typedef struct {
    logic signed [15:0] ref_re;
    logic signed [15:0] ref_im;
    logic signed [15:0] meas_re;
    logic signed [15:0] meas_im;
  } sample_t;

  typedef struct {
    logic [31:0] est;
    logic [9:0]  idx;
    logic        sat;
  } estimate_t;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [sinr_est_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [sinr_est_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] ref_re = '0, ref_im = '0, meas_re = '0, meas_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] sinr_estimate;
  logic [9:0] subcarrier_index;
  logic saturated;

  sample_t pending_words[$];
  estimate_t expected_estimates[$];

  logic [47:0] ref_pwr_avg[sinr_est_pkg::MAX_SUBCARRIERS];
  logic [47:0] meas_pwr_avg[sinr_est_pkg::MAX_SUBCARRIERS];
  int unsigned sym_pos, phase_cnt;
  int unsigned len_reg, spc_reg, alpha_reg;

  int unsigned send_idle_pct = 0, stall_pct = 0;
  bit in_took = 1'b0;
  int unsigned words_in = 0, results_out = 0, mismatches = 0, idle_cycles = 0;
  int unsigned phase_total = 0;

  per_subcarrier_sinr_estimator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .ref_re_i(ref_re), .ref_im_i(ref_im), .meas_re_i(meas_re), .meas_im_i(meas_im),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sinr_estimate_o(sinr_estimate), .subcarrier_index_o(subcarrier_index),
    .saturated_o(saturated)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] power_q46(logic signed [15:0] re, logic signed [15:0] im);
    longint a, b;
    a = re;
    b = im;
    return 64'(a * a + b * b) << 16;
  endfunction

  function automatic logic [47:0] smooth_avg(logic [47:0] avg, logic [63:0] pwr,
                                              int unsigned alpha);
    logic [65:0] acc;
    acc = 66'(alpha) * 66'(pwr) + 66'(65536 - alpha) * 66'(avg) + 66'd32768;
    return acc[63:16];
  endfunction

  task automatic predict_estimate(sample_t s);
    int unsigned len, spc, pos;
    logic [47:0] r, m;
    logic [63:0] q, rem, frac;
    estimate_t e;
    len = (len_reg == 0) ? 1 : (len_reg > sinr_est_pkg::MAX_SUBCARRIERS ?
                                sinr_est_pkg::MAX_SUBCARRIERS : len_reg);
    spc = (spc_reg == 0) ? 1 : spc_reg;
    pos = sym_pos % sinr_est_pkg::MAX_SUBCARRIERS;
    if (phase_cnt != 0) begin
      r = smooth_avg(ref_pwr_avg[pos], power_q46(s.ref_re, s.ref_im), alpha_reg);
      m = smooth_avg(meas_pwr_avg[pos], power_q46(s.meas_re, s.meas_im), alpha_reg);
      ref_pwr_avg[pos] = r;
      meas_pwr_avg[pos] = m;
      e.idx = pos[9:0];
      e.sat = 1'b0;
      if (r == 0) begin
        e.est = sinr_est_pkg::SAT_MAX;
        e.sat = 1'b1;
      end else begin
        q = m / r;
        rem = m % r;
        frac = (rem << 16) / r;
        if (q > 32768) begin
          e.est = sinr_est_pkg::SAT_MAX;
          e.sat = 1'b1;
        end else begin
          e.est = 32'((q << 16) + frac - 65536);
        end
      end
      expected_estimates.push_back(e);
    end
    if (pos + 1 >= len) begin
      sym_pos = 0;
      phase_cnt = 0;
    end else begin
      sym_pos = pos + 1;
      phase_cnt = (phase_cnt + 1 >= spc) ? 0 : phase_cnt + 1;
    end
  endtask

  // monitor: track config, predict accepted words, check results
  always @(posedge clk_i) begin
    sample_t s;
    estimate_t e;
    bit busy;
    busy = 1'b0;
    in_took = 1'b0;
    if (!rst_ni) begin
      for (int i = 0; i < sinr_est_pkg::MAX_SUBCARRIERS; i++) begin
        ref_pwr_avg[i] = sinr_est_pkg::ONE_Q46;
        meas_pwr_avg[i] = sinr_est_pkg::ONE_Q46;
      end
      sym_pos = 0;
      phase_cnt = 0;
      len_reg = 64;
      spc_reg = 4;
      alpha_reg = 655;
    end else begin
      if (cfg_we) begin
        busy = 1'b1;
        case (sinr_est_pkg::cfg_reg_e'(cfg_idx))
          sinr_est_pkg::REG_ACTIVE: len_reg = cfg_data[10:0];
          sinr_est_pkg::REG_SKIP:   spc_reg = cfg_data[10:0];
          sinr_est_pkg::REG_ALPHA:  alpha_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        in_took = 1'b1;
        words_in++;
        s.ref_re = ref_re;
        s.ref_im = ref_im;
        s.meas_re = meas_re;
        s.meas_im = meas_im;
        predict_estimate(s);
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        results_out++;
        if (expected_estimates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: est=%h idx=%0d sat=%b",
                     sinr_estimate, subcarrier_index, saturated);
        end else begin
          e = expected_estimates.pop_front();
          if (sinr_estimate !== e.est || subcarrier_index !== e.idx || saturated !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp est=%h idx=%0d sat=%b, got est=%h idx=%0d sat=%b",
                       e.est, e.idx, e.sat, sinr_estimate, subcarrier_index, saturated);
          end
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // driver: present words and stall the output at the falling edge
  always @(negedge clk_i) begin
    sample_t s;
    if (rst_ni) begin
      if (!in_valid || in_took) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s = pending_words.pop_front();
          in_valid <= 1'b1;
          ref_re <= s.ref_re;
          ref_im <= s.ref_im;
          meas_re <= s.meas_re;
          meas_im <= s.meas_im;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t make_word(int rr, int ri, int mr, int mi);
    sample_t s;
    s.ref_re = 16'(rr);
    s.ref_im = 16'(ri);
    s.meas_re = 16'(mr);
    s.meas_im = 16'(mi);
    return s;
  endfunction

  task automatic write_reg(sinr_est_pkg::cfg_reg_e r, int unsigned v);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_data <= v[15:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_estimates.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    phase_total++;
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 86; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 86; end
      default: begin send_idle_pct = 26; stall_pct = 26; end
    endcase
  endtask

  initial begin
    int unsigned len, spc, alpha, n;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, field extremes
    pending_words.push_back(make_word(-32768, -32768, -32768, -32768));
    pending_words.push_back(make_word(32767, 32767, 32767, 32767));
    pending_words.push_back(make_word(0, 0, 0, 0));
    pending_words.push_back(make_word(-32768, 0, 32767, 0));
    pending_words.push_back(make_word(0, 32767, 0, -32768));
    pending_words.push_back(make_word(1, -1, -1, 1));
    pending_words.push_back(make_word(32767, 0, 0, 0));
    pending_words.push_back(make_word(0, 0, -32768, -32768));
    drain();

    // zero reference average, then ratio overflow
    write_reg(sinr_est_pkg::REG_ACTIVE, 2);
    write_reg(sinr_est_pkg::REG_SKIP, 2);
    write_reg(sinr_est_pkg::REG_ALPHA, 65535);
    for (int i = 0; i < 8; i++) pending_words.push_back(make_word(0, 0, 1000, -1000));
    for (int i = 0; i < 6; i++) pending_words.push_back(make_word(1, 0, 32767, 32767));
    for (int i = 0; i < 2; i++) pending_words.push_back(make_word(-32768, -32768, 0, 0));
    drain();

    // out-of-range lengths: zero length and spacing skip everything, then 2047 is clamped
    write_reg(sinr_est_pkg::REG_ACTIVE, 0);
    write_reg(sinr_est_pkg::REG_SKIP, 0);
    write_reg(sinr_est_pkg::REG_ALPHA, 0);
    for (int i = 0; i < 3; i++) pending_words.push_back(make_word(5, 5, 9, 9));
    drain();
    write_reg(sinr_est_pkg::REG_ACTIVE, 2047);
    write_reg(sinr_est_pkg::REG_SKIP, 2047);
    for (int i = 0; i < 4; i++) pending_words.push_back(make_word(300, -7, 12, 4000));
    drain();

    for (int k = 0; k < 9; k++) begin
      case (k % 5)
        0: len = 1024;
        1: len = 2;
        default: len = $urandom_range(2, 80);
      endcase
      case ($urandom_range(4))
        0: spc = 1;
        1: spc = 1024;
        default: spc = $urandom_range(2, len + 4);
      endcase
      case (k % 5)
        0: alpha = 65535;
        1: alpha = 1;
        2: alpha = 0;
        3: alpha = 655;
        default: alpha = $urandom_range(1, 65535);
      endcase
      write_reg(sinr_est_pkg::REG_ACTIVE, len);
      write_reg(sinr_est_pkg::REG_SKIP, spc);
      write_reg(sinr_est_pkg::REG_ALPHA, alpha);
      set_idling(k);
      n = $urandom_range(40, 60);
      for (int i = 0; i < n; i++)
        pending_words.push_back(make_word(rand_field(), rand_field(), rand_field(),
                                          rand_field()));
      drain();
    end

    $display("Covered %0d phases: %0d words in, %0d estimates checked, %0d mismatches.",
             phase_total, words_in, results_out, mismatches);
    if (mismatches == 0 && expected_estimates.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/sinr_est_pkg.sv
hw/rtl/sinr_est_ram.sv
hw/rtl/sinr_est_avg.sv
hw/rtl/sinr_est_div.sv
hw/rtl/per_subcarrier_sinr_estimator_unit.sv
sim/testbench.sv
